@@ rtl/core/bpp_pkg.sv @@
// shared types, codes and helper functions of the blame porcelain parser
// no dependencies; imported by every module of the block
package bpp_pkg;

    localparam int HASH_CHARS_DEF = 40;
    localparam int PREFIX_LEN     = 12;
    localparam int AUTHOR_SPACE   = 6;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    localparam logic [63:0] TIME_PRE_LIMIT = 64'd922337203685477580;
    localparam logic [63:0] TIME_TWO63     = 64'h8000000000000000;

    // time flag bits
    localparam int TF_SIGN  = 0;
    localparam int TF_DIGIT = 1;
    localparam int TF_FAULT = 2;

    typedef enum logic [2:0] {
        KIND_HASH    = 3'd0,
        KIND_AUTH_BG = 3'd1,
        KIND_AUTH    = 3'd2,
        KIND_TIME    = 3'd3,
        KIND_CONTENT = 3'd4,
        KIND_REC_END = 3'd5,
        KIND_DONE    = 3'd6,
        KIND_ERROR   = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        ERR_HEADLESS = 2'd0,
        ERR_OPEN_END = 2'd1,
        ERR_TOO_LONG = 2'd2,
        ERR_ENTRIES  = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        CL_UNDECIDED = 3'd0,
        CL_OTHER     = 3'd1,
        CL_AUTHOR    = 3'd2,
        CL_TIME      = 3'd3,
        CL_CONTENT   = 3'd4,
        CL_HEADLESS  = 3'd5
    } line_class_t;

    // register indexes on the configuration port
    localparam logic REG_MAX_RECORD = 1'b0;
    localparam logic REG_MAX_ENTRIES = 1'b1;

    // command and status between the sequencer and the time unit
    typedef struct packed {
        logic       clear;
        logic       feed;
        logic [7:0] ch;
    } time_cmd_t;

    typedef struct packed {
        logic        ok;
        logic [63:0] value;
    } time_res_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39);
    endfunction

    // "author-time " one character per position
    function automatic logic [7:0] prefix_char(input logic [3:0] pos);
        logic [7:0] r;
        r = 8'h00;
        case (pos)
            4'd0:  r = 8'h61;
            4'd1:  r = 8'h75;
            4'd2:  r = 8'h74;
            4'd3:  r = 8'h68;
            4'd4:  r = 8'h6f;
            4'd5:  r = 8'h72;
            4'd6:  r = 8'h2d;
            4'd7:  r = 8'h74;
            4'd8:  r = 8'h69;
            4'd9:  r = 8'h6d;
            4'd10: r = 8'h65;
            4'd11: r = 8'h20;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/bpp_token_mem.sv @@
// token store of the first token of a line, one byte per entry
// synchronous memory with one write port and one registered read port; uses bpp_pkg
module bpp_token_mem #(
    parameter int DEPTH = bpp_pkg::HASH_CHARS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);
    import bpp_pkg::*;

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/bpp_time_unit.sv @@
// decimal parser for the author-time value, one character per feed
// holds accumulator and flags; uses bpp_pkg types
module bpp_time_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  bpp_pkg::time_cmd_t  cmd,
    output bpp_pkg::time_res_t  res
);
    import bpp_pkg::*;

    logic [63:0] acc_reg, acc_next;
    logic [2:0]  flags_reg, flags_next;
    logic [63:0] acc_times10;

    assign acc_times10 = (acc_reg << 3) + (acc_reg << 1) + {60'd0, cmd.ch[3:0]};

    // accumulate one character
    always_comb begin
        acc_next   = acc_reg;
        flags_next = flags_reg;
        if (cmd.clear) begin
            acc_next   = '0;
            flags_next = '0;
        end else if (cmd.feed && !flags_reg[TF_FAULT]) begin
            if (cmd.ch == CH_MINUS && flags_reg == 3'd0) begin
                flags_next[TF_SIGN] = 1'b1;
            end else if (is_digit(cmd.ch)) begin
                if (acc_reg > TIME_PRE_LIMIT) begin
                    flags_next[TF_FAULT] = 1'b1;
                end else begin
                    acc_next = acc_times10;
                    flags_next[TF_DIGIT] = 1'b1;
                    if (acc_times10 > TIME_TWO63) begin
                        flags_next[TF_FAULT] = 1'b1;
                    end
                end
            end else begin
                flags_next[TF_FAULT] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            flags_reg <= '0;
        end else begin
            acc_reg   <= acc_next;
            flags_reg <= flags_next;
        end
    end

    // value at line end
    assign res.ok = flags_reg[TF_DIGIT] && !flags_reg[TF_FAULT] &&
                    (flags_reg[TF_SIGN] || !acc_reg[63]);
    assign res.value = flags_reg[TF_SIGN] ? (64'd0 - acc_reg) : acc_reg;

endmodule

@@ rtl/core/blame_porcelain_parser.sv @@
// blame line-porcelain parser: byte stream in, classified transactions out
// depends on bpp_pkg, bpp_token_mem and bpp_time_unit
//
// usage:
//   s_ channel carries one text byte per transaction: s_tdata is the byte,
//   s_tuser says the byte is present, s_tlast ends the text after it.
//   m_ channel carries results: m_tuser is the kind, m_tlast marks the last
//   result caused by one input transaction.
//   the APB port sets the record byte limit (0x0) and the entry limit (0x4).
// steps:
//   an ordinary byte is accepted, then handled by the sequencer step; a newline
//   byte is accepted, then handled by the line-end step, and a partial line closed
//   by the end of the text adds a line-end step. a hash line end reads the token memory
//   one entry at a time (read, then emit) until all HASH_CHARS entries are sent.
//   the end of the text adds a step for the done or error transaction,
//   and an entry overflow adds a step for its error after the record end.
// reset clears all control state; no memory clearing pass is needed.
// a stalled receiver holds the output register; the sequencer waits on it
// and input is held off until the current item is finished.
module blame_porcelain_parser #(
    parameter int HASH_CHARS = bpp_pkg::HASH_CHARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_valid
    input  logic        s_tlast,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [7:0] text_byte, [71:8] time_value, [73:72] error_code
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bpp_pkg::*;

    localparam int AW   = $clog2(HASH_CHARS);
    localparam int TC_W = $clog2(HASH_CHARS + 2);
    localparam logic [TC_W-1:0] HASH_TC  = TC_W'(HASH_CHARS);
    localparam logic [AW-1:0]   HASH_END = AW'(HASH_CHARS - 1);
    localparam logic [24:0]     SAT25    = '1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_BYTE, ST_LEND, ST_HASH_RD, ST_HASH_EM, ST_REC_ERR, ST_FINAL
    } state_t;

    state_t state_reg, state_next;

    logic [23:0] max_rec_reg, max_ent_reg;

    logic [7:0]  ch_reg, ch_next;
    logic        eod_reg, eod_next;

    logic              line_started_reg, line_started_next;
    line_class_t       class_reg, class_next;
    logic [TC_W-1:0]   tc_reg, tc_next;
    logic              all_hex_reg, all_hex_next;
    logic              tok_open_reg, tok_open_next;
    logic [3:0]        pp_reg, pp_next;
    logic [24:0]       rb_reg, rb_next;
    logic              in_rec_reg, in_rec_next;
    logic [24:0]       ec_reg, ec_next;
    logic              stopped_reg, stopped_next;
    logic [AW-1:0]     idx_reg, idx_next;

    logic        m_valid_reg, m_valid_next;
    kind_t       kind_reg, kind_next;
    logic [7:0]  text_reg, text_next;
    logic [63:0] time_reg, time_next;
    logic [1:0]  err_reg, err_next;
    logic        last_reg, last_next;

    logic        mem_we, mem_re;
    logic [7:0]  mem_rdata;
    time_cmd_t   tcmd;
    time_res_t   tres;

    logic        out_free;
    logic        line_clr, text_clr;
    logic [24:0] rb_inc, ec_inc;
    logic        ent_over;

    bpp_token_mem #(.DEPTH(HASH_CHARS), .AW(AW)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (tc_reg[AW-1:0]),
        .wdata (ch_reg),
        .re    (mem_re),
        .raddr (idx_reg),
        .rdata (mem_rdata)
    );

    bpp_time_unit u_time (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (tcmd),
        .res     (tres)
    );

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_ENTRIES) ? {8'd0, max_ent_reg} : {8'd0, max_rec_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_rec_reg <= 24'd65536;
            max_ent_reg <= 24'd1048576;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_MAX_ENTRIES) begin
                max_ent_reg <= pwdata[23:0];
            end else begin
                max_rec_reg <= pwdata[23:0];
            end
        end
    end

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign rb_inc   = (rb_reg == SAT25) ? rb_reg : rb_reg + 25'd1;
    assign ec_inc   = (ec_reg == SAT25) ? ec_reg : ec_reg + 25'd1;
    assign ent_over = ec_inc > {1'b0, max_ent_reg};

    // sequencer: one step per cycle, each emit waits for a free output register
    always_comb begin
        state_next        = state_reg;
        ch_next           = ch_reg;
        eod_next          = eod_reg;
        line_started_next = line_started_reg;
        class_next        = class_reg;
        tc_next           = tc_reg;
        all_hex_next      = all_hex_reg;
        tok_open_next     = tok_open_reg;
        pp_next           = pp_reg;
        rb_next           = rb_reg;
        in_rec_next       = in_rec_reg;
        ec_next           = ec_reg;
        stopped_next      = stopped_reg;
        idx_next          = idx_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        kind_next         = kind_reg;
        text_next         = text_reg;
        time_next         = time_reg;
        err_next          = err_reg;
        last_next         = last_reg;
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        tcmd.clear        = 1'b0;
        tcmd.feed         = 1'b0;
        tcmd.ch           = ch_reg;
        line_clr          = 1'b0;
        text_clr          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ch_next  = s_tdata;
                    eod_next = s_tlast;
                    if (stopped_reg) begin
                        text_clr = s_tlast;
                    end else if (s_tuser && s_tdata == CH_LF) begin
                        state_next = ST_LEND;
                    end else if (s_tuser) begin
                        state_next = ST_BYTE;
                    end else if (s_tlast) begin
                        state_next = line_started_reg ? ST_LEND : ST_FINAL;
                    end
                end
            end

            ST_BYTE: begin
                if (out_free) begin
                    line_started_next = 1'b1;
                    rb_next = rb_inc;
                    // first token capture
                    if (tok_open_reg) begin
                        if (ch_reg == CH_SPACE) begin
                            tok_open_next = 1'b0;
                        end else begin
                            mem_we = (tc_reg < HASH_TC);
                            if (tc_reg <= HASH_TC) begin
                                tc_next = tc_reg + TC_W'(1);
                            end
                            if (!is_hex(ch_reg)) begin
                                all_hex_next = 1'b0;
                            end
                        end
                    end
                    // line classification
                    text_next = 8'd0;
                    time_next = 64'd0;
                    err_next  = 2'd0;
                    last_next = !eod_reg;
                    case (class_reg)
                        CL_UNDECIDED: begin
                            if (pp_reg == 4'd0 && ch_reg == CH_TAB) begin
                                class_next = in_rec_reg ? CL_CONTENT : CL_HEADLESS;
                            end else if (pp_reg == 4'(AUTHOR_SPACE) && ch_reg == CH_SPACE) begin
                                class_next   = CL_AUTHOR;
                                m_valid_next = 1'b1;
                                kind_next    = KIND_AUTH_BG;
                            end else if (pp_reg < 4'(PREFIX_LEN) &&
                                         ch_reg == prefix_char(pp_reg)) begin
                                pp_next = pp_reg + 4'd1;
                                if (pp_reg == 4'(PREFIX_LEN - 1)) begin
                                    class_next = CL_TIME;
                                end
                            end else begin
                                class_next = CL_OTHER;
                            end
                        end
                        CL_AUTHOR: begin
                            m_valid_next = 1'b1;
                            kind_next    = KIND_AUTH;
                            text_next    = ch_reg;
                        end
                        CL_TIME: begin
                            tcmd.feed = 1'b1;
                        end
                        CL_CONTENT: begin
                            m_valid_next = 1'b1;
                            kind_next    = KIND_CONTENT;
                            text_next    = ch_reg;
                        end
                        default: begin
                        end
                    endcase
                    state_next = eod_reg ? ST_LEND : ST_IDLE;
                end
            end

            ST_LEND: begin
                if (out_free) begin
                    rb_next   = rb_inc;
                    text_next = 8'd0;
                    time_next = 64'd0;
                    err_next  = 2'd0;
                    last_next = 1'b1;
                    state_next = eod_reg ? ST_FINAL : ST_IDLE;
                    if (rb_inc > {1'b0, max_rec_reg}) begin
                        // record too long
                        m_valid_next = 1'b1;
                        kind_next    = KIND_ERROR;
                        err_next     = ERR_TOO_LONG;
                        stopped_next = 1'b1;
                        text_clr     = eod_reg;
                        state_next   = ST_IDLE;
                    end else begin
                        case (class_reg) inside
                            CL_CONTENT: begin
                                m_valid_next = 1'b1;
                                kind_next    = KIND_REC_END;
                                last_next    = !ent_over && !eod_reg;
                                in_rec_next  = 1'b0;
                                rb_next      = 25'd0;
                                ec_next      = ec_inc;
                                line_clr     = 1'b1;
                                if (ent_over) begin
                                    state_next = ST_REC_ERR;
                                end
                            end
                            CL_HEADLESS: begin
                                m_valid_next = 1'b1;
                                kind_next    = KIND_ERROR;
                                err_next     = ERR_HEADLESS;
                                stopped_next = 1'b1;
                                text_clr     = eod_reg;
                                state_next   = ST_IDLE;
                            end
                            CL_TIME: begin
                                if (tres.ok) begin
                                    m_valid_next = 1'b1;
                                    kind_next    = KIND_TIME;
                                    time_next    = tres.value;
                                    last_next    = !eod_reg;
                                end
                                line_clr = 1'b1;
                            end
                            CL_UNDECIDED, CL_OTHER: begin
                                if (tc_reg == HASH_TC && all_hex_reg) begin
                                    in_rec_next = 1'b1;
                                    idx_next    = '0;
                                    state_next  = ST_HASH_RD;
                                end else begin
                                    line_clr = 1'b1;
                                end
                            end
                            default: begin
                                line_clr = 1'b1;
                            end
                        endcase
                    end
                end
            end

            ST_HASH_RD: begin
                mem_re     = 1'b1;
                state_next = ST_HASH_EM;
            end

            ST_HASH_EM: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    kind_next    = KIND_HASH;
                    text_next    = mem_rdata;
                    time_next    = 64'd0;
                    err_next     = 2'd0;
                    last_next    = (idx_reg == HASH_END) && !eod_reg;
                    if (idx_reg == HASH_END) begin
                        line_clr   = 1'b1;
                        state_next = eod_reg ? ST_FINAL : ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_HASH_RD;
                    end
                end
            end

            ST_REC_ERR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    kind_next    = KIND_ERROR;
                    text_next    = 8'd0;
                    time_next    = 64'd0;
                    err_next     = ERR_ENTRIES;
                    last_next    = 1'b1;
                    stopped_next = 1'b1;
                    text_clr     = eod_reg;
                    state_next   = ST_IDLE;
                end
            end

            ST_FINAL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    kind_next    = in_rec_reg ? KIND_ERROR : KIND_DONE;
                    text_next    = 8'd0;
                    time_next    = 64'd0;
                    err_next     = in_rec_reg ? ERR_OPEN_END : 2'd0;
                    last_next    = 1'b1;
                    text_clr     = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // line and text clearing
        if (line_clr || text_clr) begin
            line_started_next = 1'b0;
            class_next        = CL_UNDECIDED;
            tc_next           = '0;
            all_hex_next      = 1'b1;
            tok_open_next     = 1'b1;
            pp_next           = 4'd0;
            tcmd.clear        = 1'b1;
        end
        if (text_clr) begin
            rb_next      = 25'd0;
            in_rec_next  = 1'b0;
            ec_next      = 25'd0;
            stopped_next = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            eod_reg          <= 1'b0;
            line_started_reg <= 1'b0;
            class_reg        <= CL_UNDECIDED;
            tc_reg           <= '0;
            all_hex_reg      <= 1'b1;
            tok_open_reg     <= 1'b1;
            pp_reg           <= 4'd0;
            rb_reg           <= 25'd0;
            in_rec_reg       <= 1'b0;
            ec_reg           <= 25'd0;
            stopped_reg      <= 1'b0;
            idx_reg          <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            eod_reg          <= eod_next;
            line_started_reg <= line_started_next;
            class_reg        <= class_next;
            tc_reg           <= tc_next;
            all_hex_reg      <= all_hex_next;
            tok_open_reg     <= tok_open_next;
            pp_reg           <= pp_next;
            rb_reg           <= rb_next;
            in_rec_reg       <= in_rec_next;
            ec_reg           <= ec_next;
            stopped_reg      <= stopped_next;
            idx_reg          <= idx_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        ch_reg   <= ch_next;
        kind_reg <= kind_next;
        text_reg <= text_next;
        time_reg <= time_next;
        err_reg  <= err_next;
        last_reg <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {6'd0, err_reg, time_reg, text_reg};
    assign m_tlast  = last_reg;

    // a hash burst only runs on a full-length token
    a_hash_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HASH_EM) |-> (tc_reg == HASH_TC && all_hex_reg))
        else $error("hash burst without a full token");

    // done and error transactions always close an input item
    a_final_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (kind_reg == KIND_DONE || kind_reg == KIND_ERROR)) |-> last_reg)
        else $error("done or error without last");

    // a stopped parser sits idle waiting for end of text
    a_stop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |-> (state_reg == ST_IDLE))
        else $error("sequencer busy while stopped");

    // an emit never overwrites a transaction that was not taken
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(kind_reg) && $stable(text_reg)))
        else $error("output overwritten under stall");

endmodule

@@ tb/sv/blame_porcelain_parser_test.sv @@
// testbench for blame_porcelain_parser: drives blame text bytes, predicts every result
// depends on bpp_pkg and the blame_porcelain_parser rtl
`timescale 1ns / 100ps

import bpp_pkg::*;

typedef struct {
    kind_t       kind;
    logic [7:0]  text;
    logic [63:0] tval;
    err_t        err;
    logic        last;
} blame_result_t;

// predicts parser results and matches them against the result stream
class blame_scoreboard;
    blame_result_t expected_q[$];
    int          errors;
    int          results_seen;
    logic [23:0] rec_limit;
    logic [23:0] ent_limit;

    string       time_prefix;
    bit          line_started;
    line_class_t line_class;
    logic [7:0]  token_store[HASH_CHARS_DEF];
    int          token_count;
    bit          token_all_hex;
    bit          token_open;
    int          prefix_pos;
    logic [63:0] time_acc;
    bit          t_sign;
    bit          t_digit;
    bit          t_fault;
    logic [24:0] rec_bytes;
    bit          rec_open;
    logic [24:0] entry_count;
    bit          stopped;

    function new();
        time_prefix = "author-time ";
        rec_limit = 24'd65536;
        ent_limit = 24'd1048576;
        errors = 0;
        results_seen = 0;
        clear_text();
    endfunction

    function void clear_line();
        line_started = 0;
        line_class = CL_UNDECIDED;
        token_count = 0;
        token_all_hex = 1;
        token_open = 1;
        prefix_pos = 0;
        time_acc = '0;
        t_sign = 0;
        t_digit = 0;
        t_fault = 0;
    endfunction

    function void clear_text();
        clear_line();
        rec_bytes = '0;
        rec_open = 0;
        entry_count = '0;
        stopped = 0;
    endfunction

    function void emit(kind_t k, logic [7:0] b, logic [63:0] tv, err_t e);
        blame_result_t r;
        r.kind = k;
        r.text = b;
        r.tval = tv;
        r.err = e;
        r.last = 0;
        expected_q = {expected_q, r};
    endfunction

    function void raise_err(err_t e);
        emit(KIND_ERROR, 8'h00, 64'd0, e);
        stopped = 1;
    endfunction

    function bit hex_char(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function void feed_time(logic [7:0] c);
        if (t_fault)
            return;
        if (c == CH_MINUS && !t_sign && !t_digit) begin
            t_sign = 1;
        end else if (c >= "0" && c <= "9") begin
            if (time_acc > 64'd922337203685477580) begin
                t_fault = 1;
                return;
            end
            time_acc = time_acc * 10 + (c - "0");
            if (time_acc > 64'h8000000000000000)
                t_fault = 1;
            t_digit = 1;
        end else begin
            t_fault = 1;
        end
    endfunction

    function void take_byte(logic [7:0] c);
        line_started = 1;
        if (rec_bytes != '1)
            rec_bytes++;
        if (token_open) begin
            if (c == CH_SPACE) begin
                token_open = 0;
            end else begin
                if (token_count < HASH_CHARS_DEF)
                    token_store[token_count] = c;
                if (token_count <= HASH_CHARS_DEF)
                    token_count++;
                if (!hex_char(c))
                    token_all_hex = 0;
            end
        end
        case (line_class)
            CL_UNDECIDED: begin
                if (prefix_pos == 0 && c == CH_TAB) begin
                    line_class = rec_open ? CL_CONTENT : CL_HEADLESS;
                end else if (prefix_pos == 6 && c == CH_SPACE) begin
                    line_class = CL_AUTHOR;
                    emit(KIND_AUTH_BG, 8'h00, 64'd0, ERR_HEADLESS);
                end else if (prefix_pos < 12 && c == time_prefix[prefix_pos]) begin
                    prefix_pos++;
                    if (prefix_pos == 12)
                        line_class = CL_TIME;
                end else begin
                    line_class = CL_OTHER;
                end
            end
            CL_AUTHOR:  emit(KIND_AUTH, c, 64'd0, ERR_HEADLESS);
            CL_TIME:    feed_time(c);
            CL_CONTENT: emit(KIND_CONTENT, c, 64'd0, ERR_HEADLESS);
            default: ;
        endcase
    endfunction

    function void end_line();
        if (rec_bytes != '1)
            rec_bytes++;
        if (rec_bytes > {1'b0, rec_limit}) begin
            raise_err(ERR_TOO_LONG);
            return;
        end
        case (line_class) inside
            CL_CONTENT: begin
                emit(KIND_REC_END, 8'h00, 64'd0, ERR_HEADLESS);
                rec_open = 0;
                rec_bytes = '0;
                if (entry_count != '1)
                    entry_count++;
                if (entry_count > {1'b0, ent_limit}) begin
                    raise_err(ERR_ENTRIES);
                    return;
                end
            end
            CL_HEADLESS: begin
                raise_err(ERR_HEADLESS);
                return;
            end
            CL_TIME: begin
                if (t_digit && !t_fault && (t_sign || time_acc < 64'h8000000000000000))
                    emit(KIND_TIME, 8'h00, t_sign ? -time_acc : time_acc, ERR_HEADLESS);
            end
            CL_UNDECIDED, CL_OTHER: begin
                if (token_count == HASH_CHARS_DEF && token_all_hex) begin
                    foreach (token_store[i])
                        emit(KIND_HASH, token_store[i], 64'd0, ERR_HEADLESS);
                    rec_open = 1;
                end
            end
            default: ;
        endcase
        clear_line();
    endfunction

    // one accepted input transaction
    function void note_input(logic [7:0] c, bit valid, bit eod);
        int start;
        start = expected_q.size();
        if (stopped) begin
            if (eod)
                clear_text();
            return;
        end
        if (valid) begin
            if (c == CH_LF)
                end_line();
            else
                take_byte(c);
        end
        if (eod) begin
            if (!stopped && line_started)
                end_line();
            if (!stopped) begin
                if (rec_open)
                    raise_err(ERR_OPEN_END);
                else
                    emit(KIND_DONE, 8'h00, 64'd0, ERR_HEADLESS);
            end
            clear_text();
        end
        if (expected_q.size() > start)
            expected_q[expected_q.size() - 1].last = 1;
    endfunction

    // one accepted result transaction
    function void check_result(logic [2:0] kind, logic [79:0] data, logic last);
        blame_result_t e;
        results_seen++;
        if (expected_q.size() == 0) begin
            $error("unexpected result: kind %0d data %h", kind, data);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (kind !== e.kind) begin
            $error("kind: expected %0d actual %0d", e.kind, kind);
            errors++;
        end
        if (data[7:0] !== e.text) begin
            $error("text_byte: expected %h actual %h", e.text, data[7:0]);
            errors++;
        end
        if (data[71:8] !== e.tval) begin
            $error("time_value: expected %0d actual %0d", $signed(e.tval), $signed(data[71:8]));
            errors++;
        end
        if (data[73:72] !== e.err) begin
            $error("error_code: expected %0d actual %0d", e.err, data[73:72]);
            errors++;
        end
        if (last !== e.last) begin
            $error("last: expected %0d actual %0d", e.last, last);
            errors++;
        end
    endfunction
endclass

module blame_porcelain_parser_test;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [79:0] m_tdata;   // [7:0] text_byte, [71:8] time_value, [73:72] error_code
    logic [2:0]  m_tuser;   // [2:0] kind
    logic        m_tlast;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    blame_scoreboard sb = new();
    int  cyc = 0;
    int  items_sent = 0;
    int  texts_sent = 0;
    bit  hold_req = 0;

    blame_porcelain_parser dut (.*);

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    always @(posedge aclk)
        cyc <= cyc + 1;

    // result side: random stalls, quiet stretches, one long hold-off
    always @(negedge aclk) begin
        static int hold_left = -1;
        if (hold_req && hold_left == -1)
            hold_left = 400;
        if (hold_left > 0) begin
            m_tready <= 0;
            hold_left--;
            if (hold_left == 0)
                hold_left = -2;
        end else begin
            m_tready <= ((cyc % 3000) < 700) || ($urandom_range(99) >= 24);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata, m_tlast);
    end

    // one input transaction, with random idle cycles ahead of it
    task automatic send_item(logic [7:0] c, bit valid, bit eod);
        while (!((cyc % 2500) < 600) && $urandom_range(99) < 24) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= c;
        s_tuser <= valid;
        s_tlast <= eod;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_input(c, valid, eod);
        items_sent++;
        @(negedge aclk);
    endtask

    // a whole text; eod rides on the last byte, or on an empty item
    task automatic send_text(byte unsigned t[$], bit eod);
        foreach (t[i]) begin
            if ($urandom_range(99) < 3)
                send_item(8'($urandom), 0, 0);
            send_item(t[i], 1, eod && i == t.size() - 1);
        end
        if (eod && t.size() == 0)
            send_item(8'($urandom), 0, 1);
        texts_sent += eod;
    endtask

    task automatic push_str(ref byte unsigned t[$], input string s);
        for (int i = 0; i < s.len(); i++)
            t = {t, s[i]};
    endtask

    task automatic wait_idle();
        s_tvalid <= 0;
        while (sb.expected_q.size() != 0)
            @(negedge aclk);
        repeat (120) @(negedge aclk);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [23:0] val);
        @(negedge aclk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= addr;
        pwdata <= {8'h00, val};
        @(negedge aclk);
        penable <= 1;
        @(negedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (addr[2] == REG_MAX_RECORD)
            sb.rec_limit = val;
        else
            sb.ent_limit = val;
    endtask

    task automatic set_limits(logic [23:0] rec, logic [23:0] ent);
        wait_idle();
        reg_write({REG_MAX_RECORD, 2'b00}, rec);
        reg_write({REG_MAX_ENTRIES, 2'b00}, ent);
    endtask

    function automatic string hash_text(int n);
        string s;
        string digits;
        s = "";
        digits = "0123456789abcdefABCDEF";
        for (int i = 0; i < n; i++)
            s = {s, string'(digits[$urandom_range(21)])};
        if ($urandom_range(9) == 0)
            s[$urandom_range(n - 1)] = "g";
        return s;
    endfunction

    function automatic string time_text();
        case ($urandom_range(11))
            0: return "9223372036854775807";
            1: return "-9223372036854775808";
            2: return "9223372036854775808";
            3: return "-9223372036854775809";
            4: return "99999999999999999999";
            5: return "-";
            6: return "";
            7: return "12x4";
            8: return $sformatf("-%0d", $urandom);
            default: return $sformatf("%0d", {$urandom, $urandom});
        endcase
    endfunction

    // one blame record, mostly well formed
    task automatic add_record(ref byte unsigned t[$]);
        int n;
        n = ($urandom_range(9) == 0) ? 39 + 2 * $urandom_range(1) : HASH_CHARS_DEF;
        push_str(t, hash_text(n));
        if ($urandom_range(1))
            push_str(t, $sformatf(" %0d %0d", $urandom_range(99), $urandom_range(99)));
        push_str(t, "\n");
        if ($urandom_range(1) != 0) begin
            push_str(t, "author ");
            repeat ($urandom_range(5)) t = {t, 8'($urandom_range(32, 255))};
            push_str(t, "\n");
        end
        if ($urandom_range(1) != 0)
            push_str(t, {"author-time ", time_text(), "\n"});
        if ($urandom_range(4) == 0)
            push_str(t, "summary x\nauthor-tz +0000\nauthorx\n");
        t = {t, CH_TAB};
        repeat ($urandom_range(6)) begin
            byte unsigned b;
            b = 8'($urandom);
            t = {t, (b == CH_LF) ? 8'h00 : b};
        end
        if ($urandom_range(7) != 0)
            push_str(t, "\n");
    endtask

    initial begin
        byte unsigned t[$];
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: empty text, headless content, partial line, byte extremes
        send_item(8'hff, 0, 1);
        t = {}; push_str(t, "\tx\n"); send_text(t, 1);
        t = {}; push_str(t, "ab"); send_text(t, 1);
        t = {8'h00, 8'hff, CH_LF, CH_SPACE}; send_text(t, 1);
        t = {}; push_str(t, "author-time -5\n\t\n"); send_text(t, 0);
        send_item(8'h00, 0, 1);

        // random texts over several limit settings, extremes included
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: set_limits(24'hffffff, 24'hffffff);
                1: set_limits(24'd1, 24'd0);
                default: set_limits(24'($urandom_range(60, 200)), 24'd0);
            endcase
            if (ph == 2)
                hold_req = 1;
            t = {};
            add_record(t);
            if ($urandom_range(3) == 0)
                push_str(t, "\tstray\n");
            send_text(t, 1);
        end

        wait_idle();
        $display("covered %0d input transactions in %0d texts, %0d results checked",
                 items_sent, texts_sent, sb.results_seen);
        $display("limit settings: defaults, maxima, minima and a mid record limit under a long hold");
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #(12 * 800000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
